### hw/rtl/tmseq_pkg.sv
// Package for the two-wire master sequencer.
// Holds item codes, bus status codes, bus action codes and the result struct.
// No dependencies.
`default_nettype none

package tmseq_pkg;

  // Input item kinds.
  localparam logic [2:0] KIND_LOAD  = 3'd0;
  localparam logic [2:0] KIND_TX    = 3'd1;
  localparam logic [2:0] KIND_RX    = 3'd2;
  localparam logic [2:0] KIND_MEM   = 3'd3;
  localparam logic [2:0] KIND_EVENT = 3'd4;

  // Bus status codes carried by bus events.
  localparam logic [3:0] ST_START      = 4'd0;
  localparam logic [3:0] ST_RESTART    = 4'd1;
  localparam logic [3:0] ST_AW_ACK     = 4'd2;
  localparam logic [3:0] ST_AW_NACK    = 4'd3;
  localparam logic [3:0] ST_TXD_ACK    = 4'd4;
  localparam logic [3:0] ST_TXD_NACK   = 4'd5;
  localparam logic [3:0] ST_AR_ACK     = 4'd6;
  localparam logic [3:0] ST_AR_NACK    = 4'd7;
  localparam logic [3:0] ST_RXD_ACK    = 4'd8;
  localparam logic [3:0] ST_RXD_NACK   = 4'd9;
  localparam logic [3:0] ST_ARB_LOST   = 4'd10;

  // Bus actions.
  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_START    = 3'd1;
  localparam logic [2:0] ACT_DRIVE    = 3'd2;
  localparam logic [2:0] ACT_ACK      = 3'd3;
  localparam logic [2:0] ACT_NACK     = 3'd4;
  localparam logic [2:0] ACT_STOP     = 3'd5;
  localparam logic [2:0] ACT_NACKSTOP = 3'd6;

  // Transaction results.
  localparam logic [1:0] RES_WAIT  = 2'd0;
  localparam logic [1:0] RES_OK    = 2'd1;
  localparam logic [1:0] RES_NOACK = 2'd2;
  localparam logic [1:0] RES_LOST  = 2'd3;

  // One result beat.
  typedef struct packed {
    logic       request_refused;
    logic [2:0] bus_action;
    logic [7:0] drive_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [7:0] rx_position;
    logic [1:0] outcome;
    logic       busy_res;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/two_wire_master_sequencer_unit.sv
// Top level of the two-wire master sequencer: core, transmit store, result register.
// Depends on tmseq_pkg, tmseq_store and tmseq_core.
//
//   Channel  Handshake               Payload
//   in_      in_valid / in_ready     kind, address, count, word, load, bus status/byte
//   out_     out_valid / out_ready   refused, action, drive byte, rx byte/position,
//                                    outcome, busy
//
// One beat is accepted every cycle while the result register is empty or being
// emptied. The rate is set by the single result register and the store read
// port, which prefetches the next transmit byte. Reset is synchronous and clears
// the sequencer state; the store is not cleared and holds undefined bytes until
// loaded. A stalled output holds its beat and stops input acceptance until it
// is taken.
`default_nettype none

module two_wire_master_sequencer_unit #(
  parameter int BUFFER_DEPTH = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_kind,
  input  wire logic [6:0] in_target_address,
  input  wire logic [8:0] in_byte_count,
  input  wire logic [7:0] in_word_byte,
  input  wire logic [7:0] in_load_byte,
  input  wire logic [7:0] in_load_index,
  input  wire logic [3:0] in_bus_status,
  input  wire logic [7:0] in_bus_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_request_refused,
  output logic [2:0]      out_bus_action,
  output logic [7:0]      out_drive_byte,
  output logic            out_rx_valid,
  output logic [7:0]      out_rx_byte,
  output logic [7:0]      out_rx_position,
  output logic [1:0]      out_outcome,
  output logic            out_busy_res
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic            accept;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [7:0]      wr_data;
  logic [AW-1:0]   rd_addr;
  logic [7:0]      rd_data;
  tmseq_pkg::res_t res;
  tmseq_pkg::res_t out_res_r;
  logic            out_valid_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  tmseq_store #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tmseq_core #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .AW           (AW)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .kind           (in_kind),
    .target_address (in_target_address),
    .byte_count     (in_byte_count),
    .word_byte      (in_word_byte),
    .load_byte      (in_load_byte),
    .load_index     (in_load_index),
    .bus_status     (in_bus_status),
    .bus_byte       (in_bus_byte),
    .rd_data        (rd_data),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_addr        (rd_addr),
    .res            (res)
  );

  // Result register: valid flag is reset, payload is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_request_refused = out_res_r.request_refused;
  assign out_bus_action      = out_res_r.bus_action;
  assign out_drive_byte      = out_res_r.drive_byte;
  assign out_rx_valid        = out_res_r.rx_valid;
  assign out_rx_byte         = out_res_r.rx_byte;
  assign out_rx_position     = out_res_r.rx_position;
  assign out_outcome         = out_res_r.outcome;
  assign out_busy_res        = out_res_r.busy_res;

endmodule

`default_nettype wire

### hw/rtl/tmseq_store.sv
// Transmit byte store of the two-wire master sequencer.
// One write port, one registered read port with write-to-read forwarding.
// No package dependencies.
`default_nettype none

module tmseq_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic [7:0]         rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; a write to the address being read in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### hw/rtl/tmseq_core.sv
// Sequencer core of the two-wire master sequencer: mode, indices and result.
// Depends on tmseq_pkg; reads the transmit store through a prefetched port.
`default_nettype none

module tmseq_core #(
  parameter int BUFFER_DEPTH = 256,
  parameter int AW           = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [2:0]    kind,
  input  wire logic [6:0]    target_address,
  input  wire logic [8:0]    byte_count,
  input  wire logic [7:0]    word_byte,
  input  wire logic [7:0]    load_byte,
  input  wire logic [7:0]    load_index,
  input  wire logic [3:0]    bus_status,
  input  wire logic [7:0]    bus_byte,
  input  wire logic [7:0]    rd_data,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [7:0]         wr_data,
  output logic [AW-1:0]      rd_addr,
  output tmseq_pkg::res_t    res
);

  typedef enum logic [1:0] {MODE_IDLE, MODE_TX, MODE_RX, MODE_MEM} mode_t;

  mode_t      mode_r, mode_nxt;
  logic [6:0] peer_r, peer_nxt;
  logic [7:0] word_r, word_nxt;
  logic [8:0] tx_len_r, tx_len_nxt;
  logic [8:0] tx_pos_r, tx_pos_nxt;
  logic [8:0] rx_len_r, rx_len_nxt;
  logic [8:0] rx_cnt_r, rx_cnt_nxt;
  logic [1:0] status_r, status_nxt;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      peer_r   <= '0;
      word_r   <= '0;
      tx_len_r <= '0;
      tx_pos_r <= '0;
      rx_len_r <= '0;
      rx_cnt_r <= '0;
      status_r <= tmseq_pkg::RES_OK;
    end else begin
      mode_r   <= mode_nxt;
      peer_r   <= peer_nxt;
      word_r   <= word_nxt;
      tx_len_r <= tx_len_nxt;
      tx_pos_r <= tx_pos_nxt;
      rx_len_r <= rx_len_nxt;
      rx_cnt_r <= rx_cnt_nxt;
      status_r <= status_nxt;
    end
  end

  // Next state and result for one accepted beat.
  always_comb begin
    logic [8:0] cnt_sat;
    logic [9:0] cnt1;
    logic [9:0] cnt2;
    logic       rd_phase;

    mode_nxt   = mode_r;
    peer_nxt   = peer_r;
    word_nxt   = word_r;
    tx_len_nxt = tx_len_r;
    tx_pos_nxt = tx_pos_r;
    rx_len_nxt = rx_len_r;
    rx_cnt_nxt = rx_cnt_r;
    status_nxt = status_r;
    res        = '0;
    wr_en      = 1'b0;
    rd_phase   = 1'b0;

    cnt_sat = (32'(byte_count) > BUFFER_DEPTH) ? 9'(BUFFER_DEPTH) : byte_count;
    cnt1    = {1'b0, rx_cnt_r} + 10'd1;
    cnt2    = {1'b0, rx_cnt_r} + 10'd2;

    if (accept) begin
      case (kind)
        tmseq_pkg::KIND_LOAD: begin
          wr_en = (32'(load_index) < BUFFER_DEPTH);
        end
        tmseq_pkg::KIND_TX, tmseq_pkg::KIND_RX, tmseq_pkg::KIND_MEM: begin
          if (mode_r != MODE_IDLE) begin
            res.request_refused = 1'b1;
          end else begin
            peer_nxt       = target_address;
            status_nxt     = tmseq_pkg::RES_WAIT;
            res.bus_action = tmseq_pkg::ACT_START;
            if (kind == tmseq_pkg::KIND_TX) begin
              mode_nxt   = MODE_TX;
              tx_len_nxt = cnt_sat;
              tx_pos_nxt = '0;
            end else begin
              mode_nxt   = (kind == tmseq_pkg::KIND_RX) ? MODE_RX : MODE_MEM;
              rx_len_nxt = cnt_sat;
              rx_cnt_nxt = '0;
              if (kind == tmseq_pkg::KIND_MEM) begin
                word_nxt = word_byte;
              end
            end
          end
        end
        tmseq_pkg::KIND_EVENT: begin
          case (mode_r)
            // Transmit: address, then bytes from the store.
            MODE_TX: begin
              case (bus_status)
                tmseq_pkg::ST_START, tmseq_pkg::ST_RESTART: begin
                  res.bus_action = tmseq_pkg::ACT_DRIVE;
                  res.drive_byte = {peer_r, 1'b0};
                end
                tmseq_pkg::ST_AW_ACK, tmseq_pkg::ST_TXD_ACK: begin
                  if (tx_pos_r >= tx_len_r) begin
                    status_nxt     = tmseq_pkg::RES_OK;
                    res.bus_action = tmseq_pkg::ACT_STOP;
                  end else begin
                    res.bus_action = tmseq_pkg::ACT_DRIVE;
                    res.drive_byte = rd_data;
                    tx_pos_nxt     = tx_pos_r + 9'd1;
                  end
                end
                tmseq_pkg::ST_AW_NACK: begin
                  status_nxt     = tmseq_pkg::RES_NOACK;
                  res.bus_action = tmseq_pkg::ACT_STOP;
                end
                tmseq_pkg::ST_TXD_NACK: begin
                  status_nxt     = (tx_pos_r >= tx_len_r) ? tmseq_pkg::RES_OK
                                                          : tmseq_pkg::RES_NOACK;
                  res.bus_action = tmseq_pkg::ACT_STOP;
                end
                tmseq_pkg::ST_ARB_LOST: begin
                  status_nxt     = tmseq_pkg::RES_LOST;
                  res.bus_action = tmseq_pkg::ACT_STOP;
                end
                default: ;
              endcase
            end
            // Receive: read address, then the read phase.
            MODE_RX: begin
              if (bus_status == tmseq_pkg::ST_START ||
                  bus_status == tmseq_pkg::ST_RESTART) begin
                res.bus_action = tmseq_pkg::ACT_DRIVE;
                res.drive_byte = {peer_r, 1'b1};
              end else begin
                rd_phase = 1'b1;
              end
            end
            // Memory read: write address, word byte, repeated start, read phase.
            MODE_MEM: begin
              case (bus_status)
                tmseq_pkg::ST_START: begin
                  res.bus_action = tmseq_pkg::ACT_DRIVE;
                  res.drive_byte = {peer_r, 1'b0};
                end
                tmseq_pkg::ST_RESTART: begin
                  res.bus_action = tmseq_pkg::ACT_DRIVE;
                  res.drive_byte = {peer_r, 1'b1};
                end
                tmseq_pkg::ST_AW_ACK: begin
                  res.bus_action = tmseq_pkg::ACT_DRIVE;
                  res.drive_byte = word_r;
                end
                tmseq_pkg::ST_AW_NACK, tmseq_pkg::ST_TXD_NACK: begin
                  status_nxt     = tmseq_pkg::RES_NOACK;
                  res.bus_action = tmseq_pkg::ACT_STOP;
                end
                tmseq_pkg::ST_TXD_ACK: begin
                  res.bus_action = tmseq_pkg::ACT_START;
                end
                default: begin
                  rd_phase = 1'b1;
                end
              endcase
            end
            default: ;
          endcase

          // Read phase shared by receive and memory read.
          if (rd_phase) begin
            case (bus_status)
              tmseq_pkg::ST_AR_ACK: begin
                if (rx_len_r == '0) begin
                  status_nxt     = tmseq_pkg::RES_OK;
                  res.bus_action = tmseq_pkg::ACT_STOP;
                end else begin
                  res.bus_action = (cnt1 < {1'b0, rx_len_r}) ? tmseq_pkg::ACT_ACK
                                                              : tmseq_pkg::ACT_NACK;
                end
              end
              tmseq_pkg::ST_AR_NACK: begin
                status_nxt     = tmseq_pkg::RES_NOACK;
                res.bus_action = tmseq_pkg::ACT_STOP;
              end
              tmseq_pkg::ST_RXD_ACK: begin
                if (rx_cnt_r >= rx_len_r) begin
                  status_nxt     = tmseq_pkg::RES_OK;
                  res.bus_action = tmseq_pkg::ACT_NACKSTOP;
                end else begin
                  res.rx_valid    = 1'b1;
                  res.rx_byte     = bus_byte;
                  res.rx_position = rx_cnt_r[7:0];
                  rx_cnt_nxt      = cnt1[8:0];
                  if (cnt1 >= {1'b0, rx_len_r}) begin
                    status_nxt     = tmseq_pkg::RES_OK;
                    res.bus_action = tmseq_pkg::ACT_NACKSTOP;
                  end else begin
                    res.bus_action = (cnt2 < {1'b0, rx_len_r}) ? tmseq_pkg::ACT_ACK
                                                                : tmseq_pkg::ACT_NACK;
                  end
                end
              end
              tmseq_pkg::ST_RXD_NACK: begin
                if (rx_cnt_r < rx_len_r) begin
                  res.rx_valid    = 1'b1;
                  res.rx_byte     = bus_byte;
                  res.rx_position = rx_cnt_r[7:0];
                  rx_cnt_nxt      = cnt1[8:0];
                end
                status_nxt     = tmseq_pkg::RES_OK;
                res.bus_action = tmseq_pkg::ACT_STOP;
              end
              tmseq_pkg::ST_ARB_LOST: begin
                status_nxt     = tmseq_pkg::RES_LOST;
                res.bus_action = tmseq_pkg::ACT_STOP;
              end
              default: ;
            endcase
          end

          // A finished transaction returns to idle.
          if (mode_r != MODE_IDLE && status_nxt != tmseq_pkg::RES_WAIT) begin
            mode_nxt = MODE_IDLE;
          end
        end
        default: ;
      endcase
    end

    res.outcome  = status_nxt;
    res.busy_res = (mode_nxt != MODE_IDLE);
  end

  // Store ports: writes from loads, reads prefetch the next transmit position.
  assign wr_addr = AW'(load_index);
  assign wr_data = load_byte;
  assign rd_addr = rst_n ? AW'(tx_pos_nxt) : '0;

endmodule

`default_nettype wire

### hw/rtl/tmseq_checker.sv
// Port-level checker for the two-wire master sequencer, bound to the top level.
// Depends on tmseq_pkg and two_wire_master_sequencer_unit.
`default_nettype none

module tmseq_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_request_refused,
  input wire logic [2:0] out_bus_action,
  input wire logic [7:0] out_drive_byte,
  input wire logic       out_rx_valid,
  input wire logic [7:0] out_rx_byte,
  input wire logic [7:0] out_rx_position,
  input wire logic [1:0] out_outcome,
  input wire logic       out_busy_res
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bus_action) &&
      $stable(out_drive_byte) && $stable(out_rx_byte) && $stable(out_outcome))
    else $error("result beat changed while stalled");

  // Every accepted item yields a result beat in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item gave no result beat");

  // Busy exactly while the result is still waiting.
  a_busy_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_busy_res == (out_outcome == tmseq_pkg::RES_WAIT)))
    else $error("busy and outcome disagree");

  // A refused start leaves a busy block and names no bus action.
  a_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_request_refused |->
      out_busy_res && out_bus_action == tmseq_pkg::ACT_NONE)
    else $error("refused start with action or idle block");

  // A received byte comes only with a read-phase action.
  a_rx_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rx_valid |->
      (out_bus_action == tmseq_pkg::ACT_ACK || out_bus_action == tmseq_pkg::ACT_NACK ||
       out_bus_action == tmseq_pkg::ACT_STOP ||
       out_bus_action == tmseq_pkg::ACT_NACKSTOP))
    else $error("received byte with wrong bus action");

endmodule

bind two_wire_master_sequencer_unit tmseq_checker u_tmseq_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_request_refused (out_request_refused),
  .out_bus_action      (out_bus_action),
  .out_drive_byte      (out_drive_byte),
  .out_rx_valid        (out_rx_valid),
  .out_rx_byte         (out_rx_byte),
  .out_rx_position     (out_rx_position),
  .out_outcome         (out_outcome),
  .out_busy_res        (out_busy_res)
);

`default_nettype wire

### sim/tb_two_wire_master_sequencer_unit.sv
// Self-checking testbench for the two-wire master sequencer top level.
// Runs a directed stimulus table and then random bus transactions against a behavioral predictor.
// Depends on tmseq_pkg and two_wire_master_sequencer_unit.

module tb_two_wire_master_sequencer_unit;

  localparam int BUF_DEPTH = 256;
  localparam int RANDOM_ITEMS = 1800;
  localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
  localparam logic [3:0] ST_HIGHEST = 4'd15;

  typedef enum logic [1:0] {MODE_IDLE, MODE_TX, MODE_RX, MODE_MEM} seq_mode_t;

  // One input beat as the sequencer sees it.
  typedef struct {
    logic [2:0] kind;
    logic [6:0] addr;
    logic [8:0] count;
    logic [7:0] word;
    logic [7:0] lbyte;
    logic [7:0] lidx;
    logic [3:0] status;
    logic [7:0] bbyte;
  } bus_req_t;

  // A directed row; the reply is typed in only when it is obvious.
  typedef struct {
    bus_req_t        rq;
    bit              typed;
    tmseq_pkg::res_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [2:0] in_kind;
  logic [6:0] in_target_address;
  logic [8:0] in_byte_count;
  logic [7:0] in_word_byte;
  logic [7:0] in_load_byte;
  logic [7:0] in_load_index;
  logic [3:0] in_bus_status;
  logic [7:0] in_bus_byte;
  logic out_valid;
  logic out_ready;
  logic out_request_refused;
  logic [2:0] out_bus_action;
  logic [7:0] out_drive_byte;
  logic out_rx_valid;
  logic [7:0] out_rx_byte;
  logic [7:0] out_rx_position;
  logic [1:0] out_outcome;
  logic out_busy_res;

  // Predicted sequencer state.
  seq_mode_t  ms_mode;
  logic [6:0] ms_peer;
  logic [7:0] ms_word;
  logic [8:0] ms_tx_len;
  logic [8:0] ms_tx_pos;
  logic [8:0] ms_rx_len;
  logic [8:0] ms_rx_cnt;
  logic [1:0] ms_status;
  logic [7:0] tx_image [BUF_DEPTH];
  bit         tx_loaded [BUF_DEPTH];

  tmseq_pkg::res_t awaited_replies [$];
  stim_row_t       directed_rows [$];
  logic [3:0]      wanted_status;
  int              mismatch_count = 0;
  int              useful_count = 0;
  bit              quiet_window = 1'b0;
  bit              backlog_done = 1'b0;

  two_wire_master_sequencer_unit #(.BUFFER_DEPTH(BUF_DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_target_address(in_target_address),
    .in_byte_count(in_byte_count), .in_word_byte(in_word_byte),
    .in_load_byte(in_load_byte), .in_load_index(in_load_index),
    .in_bus_status(in_bus_status), .in_bus_byte(in_bus_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_request_refused(out_request_refused), .out_bus_action(out_bus_action),
    .out_drive_byte(out_drive_byte), .out_rx_valid(out_rx_valid),
    .out_rx_byte(out_rx_byte), .out_rx_position(out_rx_position),
    .out_outcome(out_outcome), .out_busy_res(out_busy_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and reply constructors for the directed table.
  function automatic bus_req_t bus_ev(logic [3:0] st, logic [7:0] b);
    bus_req_t q;
    q = '{tmseq_pkg::KIND_EVENT, 7'd0, 9'd0, 8'd0, 8'd0, 8'd0, st, b};
    return q;
  endfunction

  function automatic bus_req_t start_req(logic [2:0] k, logic [6:0] a, logic [8:0] c,
                                         logic [7:0] w);
    bus_req_t q;
    q = '{k, a, c, w, 8'd0, 8'd0, tmseq_pkg::ST_START, 8'd0};
    return q;
  endfunction

  function automatic bus_req_t load_req(logic [7:0] b, logic [7:0] idx);
    bus_req_t q;
    q = '{tmseq_pkg::KIND_LOAD, 7'd0, 9'd0, 8'd0, b, idx, tmseq_pkg::ST_START, 8'd0};
    return q;
  endfunction

  function automatic tmseq_pkg::res_t reply(bit refused, logic [2:0] act, logic [7:0] drv,
                                            bit rxv, logic [7:0] rxb, logic [7:0] rxp,
                                            logic [1:0] outc, bit busy);
    tmseq_pkg::res_t r;
    r.request_refused = refused;
    r.bus_action = act;
    r.drive_byte = drv;
    r.rx_valid = rxv;
    r.rx_byte = rxb;
    r.rx_position = rxp;
    r.outcome = outc;
    r.busy_res = busy;
    return r;
  endfunction

  // Small pieces of the predictor.
  function automatic void conclude(logic [1:0] code, logic [2:0] act,
                                   inout tmseq_pkg::res_t r);
    ms_status = code;
    r.bus_action = act;
  endfunction

  function automatic void drive_out(logic [7:0] b, inout tmseq_pkg::res_t r);
    r.bus_action = tmseq_pkg::ACT_DRIVE;
    r.drive_byte = b;
  endfunction

  function automatic void hand_over(logic [7:0] b, inout tmseq_pkg::res_t r);
    r.rx_valid = 1'b1;
    r.rx_byte = b;
    r.rx_position = ms_rx_cnt[7:0];
    ms_rx_cnt = ms_rx_cnt + 9'd1;
  endfunction

  // ACK while more than one byte remains, NACK the last one.
  function automatic logic [2:0] read_choice();
    return (int'(ms_rx_cnt) + 1 < int'(ms_rx_len)) ? tmseq_pkg::ACT_ACK
                                                   : tmseq_pkg::ACT_NACK;
  endfunction

  // Read phase, shared by plain receive and memory read.
  function automatic void read_reply(logic [3:0] st, logic [7:0] b,
                                     inout tmseq_pkg::res_t r);
    case (st)
      tmseq_pkg::ST_AR_ACK: begin
        if (ms_rx_len == 9'd0) conclude(tmseq_pkg::RES_OK, tmseq_pkg::ACT_STOP, r);
        else r.bus_action = read_choice();
      end
      tmseq_pkg::ST_AR_NACK: conclude(tmseq_pkg::RES_NOACK, tmseq_pkg::ACT_STOP, r);
      tmseq_pkg::ST_RXD_ACK: begin
        if (ms_rx_cnt >= ms_rx_len) begin
          conclude(tmseq_pkg::RES_OK, tmseq_pkg::ACT_NACKSTOP, r);
        end else begin
          hand_over(b, r);
          if (ms_rx_cnt >= ms_rx_len) conclude(tmseq_pkg::RES_OK, tmseq_pkg::ACT_NACKSTOP, r);
          else r.bus_action = read_choice();
        end
      end
      tmseq_pkg::ST_RXD_NACK: begin
        if (ms_rx_cnt < ms_rx_len) hand_over(b, r);
        conclude(tmseq_pkg::RES_OK, tmseq_pkg::ACT_STOP, r);
      end
      tmseq_pkg::ST_ARB_LOST: conclude(tmseq_pkg::RES_LOST, tmseq_pkg::ACT_STOP, r);
      default: ;
    endcase
  endfunction

  // Works out the reply beat for one accepted input beat and advances the state.
  function automatic tmseq_pkg::res_t next_bus_reply(bus_req_t rq);
    tmseq_pkg::res_t r;
    logic [8:0] n;
    r = '0;
    n = (rq.count > 9'(BUF_DEPTH)) ? 9'(BUF_DEPTH) : rq.count;
    case (rq.kind)
      tmseq_pkg::KIND_LOAD: begin
        tx_image[rq.lidx] = rq.lbyte;
        tx_loaded[rq.lidx] = 1'b1;
      end
      tmseq_pkg::KIND_TX, tmseq_pkg::KIND_RX, tmseq_pkg::KIND_MEM: begin
        if (ms_mode != MODE_IDLE) begin
          r.request_refused = 1'b1;
        end else begin
          ms_peer = rq.addr;
          ms_status = tmseq_pkg::RES_WAIT;
          r.bus_action = tmseq_pkg::ACT_START;
          if (rq.kind == tmseq_pkg::KIND_TX) begin
            ms_mode = MODE_TX;
            ms_tx_len = n;
            ms_tx_pos = 9'd0;
          end else begin
            ms_mode = (rq.kind == tmseq_pkg::KIND_RX) ? MODE_RX : MODE_MEM;
            ms_rx_len = n;
            ms_rx_cnt = 9'd0;
            if (rq.kind == tmseq_pkg::KIND_MEM) ms_word = rq.word;
          end
        end
      end
      tmseq_pkg::KIND_EVENT: begin
        if (ms_mode == MODE_TX) begin
          case (rq.status)
            tmseq_pkg::ST_START, tmseq_pkg::ST_RESTART: drive_out({ms_peer, 1'b0}, r);
            tmseq_pkg::ST_AW_ACK, tmseq_pkg::ST_TXD_ACK: begin
              if (ms_tx_pos >= ms_tx_len) begin
                conclude(tmseq_pkg::RES_OK, tmseq_pkg::ACT_STOP, r);
              end else begin
                drive_out(tx_image[ms_tx_pos[7:0]], r);
                ms_tx_pos = ms_tx_pos + 9'd1;
              end
            end
            tmseq_pkg::ST_AW_NACK: conclude(tmseq_pkg::RES_NOACK, tmseq_pkg::ACT_STOP, r);
            tmseq_pkg::ST_TXD_NACK:
              conclude((ms_tx_pos >= ms_tx_len) ? tmseq_pkg::RES_OK : tmseq_pkg::RES_NOACK,
                       tmseq_pkg::ACT_STOP, r);
            tmseq_pkg::ST_ARB_LOST: conclude(tmseq_pkg::RES_LOST, tmseq_pkg::ACT_STOP, r);
            default: ;
          endcase
        end else if (ms_mode == MODE_RX) begin
          if (rq.status == tmseq_pkg::ST_START || rq.status == tmseq_pkg::ST_RESTART)
            drive_out({ms_peer, 1'b1}, r);
          else read_reply(rq.status, rq.bbyte, r);
        end else if (ms_mode == MODE_MEM) begin
          case (rq.status)
            tmseq_pkg::ST_START: drive_out({ms_peer, 1'b0}, r);
            tmseq_pkg::ST_RESTART: drive_out({ms_peer, 1'b1}, r);
            tmseq_pkg::ST_AW_ACK: drive_out(ms_word, r);
            tmseq_pkg::ST_AW_NACK, tmseq_pkg::ST_TXD_NACK:
              conclude(tmseq_pkg::RES_NOACK, tmseq_pkg::ACT_STOP, r);
            tmseq_pkg::ST_TXD_ACK: r.bus_action = tmseq_pkg::ACT_START;
            default: read_reply(rq.status, rq.bbyte, r);
          endcase
        end
        if (ms_status != tmseq_pkg::RES_WAIT) ms_mode = MODE_IDLE;
      end
      default: ;
    endcase
    r.outcome = ms_status;
    r.busy_res = (ms_mode != MODE_IDLE);
    return r;
  endfunction

  // Offers one input beat after a random gap and records its reply once accepted.
  task automatic send_beat(input bus_req_t rq, input bit typed, input tmseq_pkg::res_t want,
                           output tmseq_pkg::res_t predicted);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    if (quiet_window || pick < 55) gap = 0;
    else if (pick < 88) gap = $urandom_range(1, 3);
    else if (pick < 97) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_kind <= rq.kind;
    in_target_address <= rq.addr;
    in_byte_count <= rq.count;
    in_word_byte <= rq.word;
    in_load_byte <= rq.lbyte;
    in_load_index <= rq.lidx;
    in_bus_status <= rq.status;
    in_bus_byte <= rq.bbyte;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predicted = next_bus_reply(rq);
    awaited_replies.push_back(typed ? want : predicted);

    // Track which bus status a well-behaved bus would report next.
    if ((rq.kind inside {tmseq_pkg::KIND_TX, tmseq_pkg::KIND_RX, tmseq_pkg::KIND_MEM}) &&
        !predicted.request_refused) begin
      wanted_status = tmseq_pkg::ST_START;
    end else if (rq.kind == tmseq_pkg::KIND_EVENT && predicted.busy_res) begin
      case (predicted.bus_action)
        tmseq_pkg::ACT_DRIVE: begin
          if (ms_mode == MODE_TX)
            wanted_status = (rq.status == tmseq_pkg::ST_START ||
                             rq.status == tmseq_pkg::ST_RESTART) ?
                            tmseq_pkg::ST_AW_ACK : tmseq_pkg::ST_TXD_ACK;
          else if (ms_mode == MODE_RX || rq.status == tmseq_pkg::ST_RESTART)
            wanted_status = tmseq_pkg::ST_AR_ACK;
          else
            wanted_status = (rq.status == tmseq_pkg::ST_START) ?
                            tmseq_pkg::ST_AW_ACK : tmseq_pkg::ST_TXD_ACK;
        end
        tmseq_pkg::ACT_START: wanted_status = tmseq_pkg::ST_RESTART;
        tmseq_pkg::ACT_ACK: wanted_status = tmseq_pkg::ST_RXD_ACK;
        tmseq_pkg::ACT_NACK: wanted_status = tmseq_pkg::ST_RXD_NACK;
        default: ;
      endcase
    end
  endtask

  task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // Each result beat is compared with the oldest awaited reply.
  always @(posedge clk) begin
    tmseq_pkg::res_t due;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t: result beat with no reply awaited: expected none, got action %0d",
                 $time, out_bus_action);
        mismatch_count++;
      end else begin
        due = awaited_replies.pop_front();
        check_field("request_refused", due.request_refused, out_request_refused);
        check_field("bus_action", due.bus_action, out_bus_action);
        check_field("drive_byte", due.drive_byte, out_drive_byte);
        check_field("rx_valid", due.rx_valid, out_rx_valid);
        check_field("rx_byte", due.rx_byte, out_rx_byte);
        check_field("rx_position", due.rx_position, out_rx_position);
        check_field("outcome", due.outcome, out_outcome);
        check_field("busy_res", due.busy_res, out_busy_res);
      end
    end
  end

  // Result side: random stalls, long clear runs, and one long hold-off to back the block up.
  initial begin
    int stall_left;
    int run_left;
    int pick;
    stall_left = 0;
    run_left = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!backlog_done && useful_count >= 1000) begin
        backlog_done = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
      end else if (quiet_window) begin
        out_ready <= 1'b1;
      end else begin
        if (stall_left == 0 && run_left == 0) begin
          pick = $urandom_range(0, 99);
          if (pick < 60) run_left = $urandom_range(1, 8);
          else if (pick < 93) stall_left = $urandom_range(1, 3);
          else if (pick < 98) stall_left = $urandom_range(8, 40);
          else run_left = $urandom_range(50, 150);
        end
        if (run_left > 0) begin
          out_ready <= 1'b1;
          run_left--;
        end else begin
          out_ready <= 1'b0;
          stall_left--;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Reset, directed table, random transactions, drain.
  initial begin
    bus_req_t rq;
    tmseq_pkg::res_t got;
    int pick;
    int sz;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = tmseq_pkg::KIND_LOAD;
    in_target_address = '0;
    in_byte_count = '0;
    in_word_byte = '0;
    in_load_byte = '0;
    in_load_index = '0;
    in_bus_status = tmseq_pkg::ST_START;
    in_bus_byte = '0;
    ms_mode = MODE_IDLE;
    ms_peer = '0;
    ms_word = '0;
    ms_tx_len = '0;
    ms_tx_pos = '0;
    ms_rx_len = '0;
    ms_rx_cnt = '0;
    ms_status = tmseq_pkg::RES_OK;
    wanted_status = tmseq_pkg::ST_START;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Idle events, unknown kinds, loads, a two-byte write with a busy start and a stray status.
    directed_rows.push_back('{bus_ev(tmseq_pkg::ST_START, 8'h00), 1'b1,
                              reply(0, tmseq_pkg::ACT_NONE, 8'h00, 0, 8'h00, 8'h00,
                                    tmseq_pkg::RES_OK, 0)});
    directed_rows.push_back('{start_req(KIND_SPARE_LAST, 7'h7F, 9'h1FF, 8'hFF), 1'b1,
                              reply(0, tmseq_pkg::ACT_NONE, 8'h00, 0, 8'h00, 8'h00,
                                    tmseq_pkg::RES_OK, 0)});
    directed_rows.push_back('{load_req(8'hFF, 8'd0), 1'b0, '0});
    directed_rows.push_back('{load_req(8'hA5, 8'd1), 1'b0, '0});
    directed_rows.push_back('{load_req(8'h00, 8'd255), 1'b0, '0});
    directed_rows.push_back('{start_req(tmseq_pkg::KIND_TX, 7'h7F, 9'd2, 8'h00), 1'b1,
                              reply(0, tmseq_pkg::ACT_START, 8'h00, 0, 8'h00, 8'h00,
                                    tmseq_pkg::RES_WAIT, 1)});
    directed_rows.push_back('{start_req(tmseq_pkg::KIND_MEM, 7'h11, 9'd4, 8'h22), 1'b1,
                              reply(1, tmseq_pkg::ACT_NONE, 8'h00, 0, 8'h00, 8'h00,
                                    tmseq_pkg::RES_WAIT, 1)});
    directed_rows.push_back('{bus_ev(tmseq_pkg::ST_RESTART, 8'h00), 1'b1,
                              reply(0, tmseq_pkg::ACT_DRIVE, 8'hFE, 0, 8'h00, 8'h00,
                                    tmseq_pkg::RES_WAIT, 1)});
    directed_rows.push_back('{bus_ev(tmseq_pkg::ST_AW_ACK, 8'h00), 1'b0, '0});
    directed_rows.push_back('{bus_ev(ST_HIGHEST, 8'hFF), 1'b0, '0});
    directed_rows.push_back('{bus_ev(tmseq_pkg::ST_TXD_ACK, 8'h00), 1'b0, '0});
    directed_rows.push_back('{bus_ev(tmseq_pkg::ST_TXD_NACK, 8'h00), 1'b0, '0});
    // Address NACK on an empty write.
    directed_rows.push_back('{start_req(tmseq_pkg::KIND_TX, 7'h00, 9'd0, 8'h00), 1'b0, '0});
    directed_rows.push_back('{bus_ev(tmseq_pkg::ST_AW_NACK, 8'h00), 1'b1,
                              reply(0, tmseq_pkg::ACT_STOP, 8'h00, 0, 8'h00, 8'h00,
                                    tmseq_pkg::RES_NOACK, 0)});
    // Oversized read count, then lost arbitration.
    directed_rows.push_back('{start_req(tmseq_pkg::KIND_RX, 7'h55, 9'h1FF, 8'h00), 1'b0, '0});
    directed_rows.push_back('{bus_ev(tmseq_pkg::ST_START, 8'h00), 1'b0, '0});
    directed_rows.push_back('{bus_ev(tmseq_pkg::ST_ARB_LOST, 8'h00), 1'b1,
                              reply(0, tmseq_pkg::ACT_STOP, 8'h00, 0, 8'h00, 8'h00,
                                    tmseq_pkg::RES_LOST, 0)});
    // Data ACK on an empty read.
    directed_rows.push_back('{start_req(tmseq_pkg::KIND_RX, 7'h01, 9'd0, 8'h00), 1'b0, '0});
    directed_rows.push_back('{bus_ev(tmseq_pkg::ST_RXD_ACK, 8'hFF), 1'b1,
                              reply(0, tmseq_pkg::ACT_NACKSTOP, 8'h00, 0, 8'h00, 8'h00,
                                    tmseq_pkg::RES_OK, 0)});
    // Complete one-byte memory read.
    directed_rows.push_back('{start_req(tmseq_pkg::KIND_MEM, 7'h2A, 9'd1, 8'hFF), 1'b0, '0});
    directed_rows.push_back('{bus_ev(tmseq_pkg::ST_START, 8'h00), 1'b0, '0});
    directed_rows.push_back('{bus_ev(tmseq_pkg::ST_AW_ACK, 8'h00), 1'b0, '0});
    directed_rows.push_back('{bus_ev(tmseq_pkg::ST_TXD_ACK, 8'h00), 1'b0, '0});
    directed_rows.push_back('{bus_ev(tmseq_pkg::ST_RESTART, 8'h00), 1'b0, '0});
    directed_rows.push_back('{bus_ev(tmseq_pkg::ST_AR_ACK, 8'h00), 1'b0, '0});
    directed_rows.push_back('{bus_ev(tmseq_pkg::ST_RXD_NACK, 8'h3C), 1'b0, '0});

    foreach (directed_rows[i])
      send_beat(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want, got);

    // Random part: mostly well-formed transactions, with noise and stray requests mixed in.
    while (useful_count < RANDOM_ITEMS) begin
      rq.kind = tmseq_pkg::KIND_EVENT;
      rq.addr = 7'($urandom);
      rq.count = 9'($urandom);
      rq.word = 8'($urandom);
      rq.lbyte = 8'($urandom);
      rq.lidx = 8'($urandom);
      rq.status = 4'($urandom);
      rq.bbyte = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (ms_mode == MODE_IDLE) begin
        if (pick < 70) begin
          rq.kind = 3'($urandom_range(tmseq_pkg::KIND_TX, tmseq_pkg::KIND_MEM));
          sz = $urandom_range(0, 99);
          if (sz < 60) rq.count = 9'($urandom_range(0, 4));
          else if (sz < 90) rq.count = 9'($urandom_range(5, 24));
          else if (sz < 95) rq.count = 9'(BUF_DEPTH);
          else rq.count = 9'($urandom_range(BUF_DEPTH + 1, 511));
        end else if (pick < 88) begin
          rq.kind = tmseq_pkg::KIND_LOAD;
        end else if (pick >= 95) begin
          rq.kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
        end
      end else begin
        if (pick < 80) rq.status = wanted_status;
        else if (pick >= 95)
          rq.kind = 3'($urandom_range(tmseq_pkg::KIND_TX, tmseq_pkg::KIND_MEM));
        else if (pick >= 90) rq.kind = tmseq_pkg::KIND_LOAD;
      end
      // Never let the write path fetch a store entry that was never loaded.
      if (rq.kind == tmseq_pkg::KIND_EVENT && ms_mode == MODE_TX &&
          (rq.status == tmseq_pkg::ST_AW_ACK || rq.status == tmseq_pkg::ST_TXD_ACK) &&
          ms_tx_pos < ms_tx_len && !tx_loaded[ms_tx_pos[7:0]]) begin
        rq.kind = tmseq_pkg::KIND_LOAD;
        rq.lidx = ms_tx_pos[7:0];
      end
      send_beat(rq, 1'b0, '0, got);
      if (!(rq.kind > tmseq_pkg::KIND_EVENT ||
            (rq.kind == tmseq_pkg::KIND_EVENT && got.bus_action == tmseq_pkg::ACT_NONE &&
             !got.rx_valid)))
        useful_count++;
      quiet_window = (useful_count >= 400 && useful_count < 600);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain the outstanding replies, then watch for stray beats.
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/tmseq_pkg.sv
hw/rtl/tmseq_store.sv
hw/rtl/tmseq_core.sv
hw/rtl/two_wire_master_sequencer_unit.sv
hw/rtl/tmseq_checker.sv
sim/tb_two_wire_master_sequencer_unit.sv
